FILE: src/wgdd_pkg.sv
// Package for the wait-graph deadlock detector.
// Holds sizes, the request kind codes, the state machine type and the request and result structs; no dependencies.
`default_nettype none
package wgdd_pkg;
  localparam int NUM_LOCKS = 8;
  localparam int NUM_PROCS = 8;
  localparam int NV = NUM_LOCKS + NUM_PROCS;
  localparam int VW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);
  localparam int MAX_RESULTS = 64;
  localparam int RCW = $clog2(MAX_RESULTS + 1);

  typedef logic [NV-1:0] row_t;
  typedef logic [VW-1:0] vtx_t;

  // KIND_UNREQ is internal: the second pass of an allocate, which clears the
  // request edge. Arriving as a request, the code is an unused kind and ignored.
  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_REQUEST = 3'd1,
    KIND_ALLOC   = 3'd2,
    KIND_DEALLOC = 3'd3,
    KIND_DETECT  = 3'd4,
    KIND_UNREQ   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_EDGE_RD, ST_EDGE_WR, ST_ROOT, ST_DFS_RD, ST_DFS,
    ST_TR_RD, ST_TR, ST_REACH_RD, ST_REACH, ST_EMIT, ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic [3:0] node;
    logic       node_valid;
    logic       cycle_end;
    logic       deadlock_found;
    logic       truncated;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] process_id;
    logic [2:0] lock_id;
  } request_t;
endpackage
`default_nettype wire

FILE: src/wgdd_chan_if.sv
// Valid/ready channel interface used for the request and result channels.
// Depends on nothing; the payload type is a type parameter.
`default_nettype none
interface wgdd_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/wgdd_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module wgdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/wgdd_out_reg.sv
// Output register stage for result items.
// Depends on wgdd_pkg.
`default_nettype none
module wgdd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wgdd_pkg::result_t     push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wgdd_pkg::result_t     out_data
);
  logic              valid_r;
  wgdd_pkg::result_t data_r;

  // Hold one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (push) begin
      data_r <= push_data;
    end
  end

  assign full      = valid_r && !out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule
`default_nettype wire

FILE: src/wgdd_engine.sv
// Control engine: edge edits, depth-first search and cycle tracing over the edge RAM.
// Depends on wgdd_pkg and wgdd_ram.
`default_nettype none
module wgdd_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wgdd_pkg::request_t     in_req,
  output logic                   push,
  output wgdd_pkg::result_t      push_data,
  input  wire logic              out_full
);
  localparam int NV = wgdd_pkg::NV;
  localparam int VW = wgdd_pkg::VW;
  localparam int CW = wgdd_pkg::CW;

  wgdd_pkg::state_t state_r, state_nxt;

  // Edge matrix RAM, one row per vertex.
  logic               ram_we;
  wgdd_pkg::vtx_t     ram_waddr, ram_raddr;
  wgdd_pkg::row_t     ram_wdata, ram_rdata;
  wgdd_ram #(.WIDTH(NV), .DEPTH(NV)) u_edges (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Search stack RAM: vertex and next neighbour.
  logic               stk_we;
  wgdd_pkg::vtx_t     stk_waddr, stk_raddr;
  logic [VW+CW-1:0]   stk_wdata, stk_rdata;
  wgdd_ram #(.WIDTH(VW + CW), .DEPTH(NV)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Path RAM for the traced cycle.
  logic               pth_we;
  wgdd_pkg::vtx_t     pth_waddr, pth_raddr;
  wgdd_pkg::vtx_t     pth_wdata, pth_rdata;
  wgdd_ram #(.WIDTH(VW), .DEPTH(NV)) u_path (
    .clk(clk), .we(pth_we), .waddr(pth_waddr), .wdata(pth_wdata),
    .raddr(pth_raddr), .rdata(pth_rdata)
  );

  // Control and search registers.
  wgdd_pkg::request_t req_r, req_nxt;
  wgdd_pkg::vtx_t     clr_r, clr_nxt;
  logic [CW-1:0]      root_r, root_nxt;
  logic [CW-1:0]      depth_r, depth_nxt;
  wgdd_pkg::vtx_t     v_r, v_nxt;
  logic [CW-1:0]      next_r, next_nxt;
  wgdd_pkg::row_t     visited_r, visited_nxt;
  wgdd_pkg::row_t     onpath_r, onpath_nxt;
  wgdd_pkg::row_t     tvis_r, tvis_nxt;
  wgdd_pkg::vtx_t     tv_r, tv_nxt;
  wgdd_pkg::vtx_t     cur_r, cur_nxt;
  logic [CW-1:0]      y_r, y_nxt;
  logic [CW-1:0]      len_r, len_nxt;
  wgdd_pkg::row_t     seen_r, seen_nxt;
  wgdd_pkg::row_t     prev_r, prev_nxt;
  logic [CW-1:0]      u_r, u_nxt;
  logic               hit_r, hit_nxt;
  logic               emit_rd_r, emit_rd_nxt;
  logic               found_r, found_nxt;
  logic               trunc_r, trunc_nxt;
  logic [wgdd_pkg::RCW-1:0] cnt_r, cnt_nxt;

  // Neighbour scan helpers.
  logic [CW-1:0]  a_sel;
  logic           a_hit;
  logic [CW-1:0]  ys_sel;
  logic           ys_hit;
  wgdd_pkg::vtx_t pid_v, lid_v;

  // One-hot row with a single vertex bit set.
  function automatic wgdd_pkg::row_t row_t_bit(input wgdd_pkg::vtx_t idx);
    wgdd_pkg::row_t r;
    r = '0;
    r[idx] = 1'b1;
    return r;
  endfunction

  assign pid_v = wgdd_pkg::VW'(wgdd_pkg::NUM_LOCKS) + wgdd_pkg::VW'(req_r.process_id);
  assign lid_v = wgdd_pkg::VW'(req_r.lock_id);

  // First set neighbour at or above next_r in the row just read.
  always_comb begin
    a_sel = CW'(NV);
    a_hit = 1'b0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (ram_rdata[i] && CW'(i) >= next_r) begin
        a_sel = CW'(i);
        a_hit = 1'b1;
      end
    end
  end

  // First set neighbour at or above y_r in the trace row.
  always_comb begin
    ys_sel = CW'(NV);
    ys_hit = 1'b0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (ram_rdata[i] && CW'(i) >= y_r) begin
        ys_sel = CW'(i);
        ys_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wgdd_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    req_r     <= req_nxt;
    root_r    <= root_nxt;
    depth_r   <= depth_nxt;
    v_r       <= v_nxt;
    next_r    <= next_nxt;
    visited_r <= visited_nxt;
    onpath_r  <= onpath_nxt;
    tvis_r    <= tvis_nxt;
    tv_r      <= tv_nxt;
    cur_r     <= cur_nxt;
    y_r       <= y_nxt;
    len_r     <= len_nxt;
    seen_r    <= seen_nxt;
    prev_r    <= prev_nxt;
    u_r       <= u_nxt;
    hit_r     <= hit_nxt;
    emit_rd_r <= emit_rd_nxt;
    found_r   <= found_nxt;
    trunc_r   <= trunc_nxt;
    cnt_r     <= cnt_nxt;
  end

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r; clr_nxt = clr_r; root_nxt = root_r; depth_nxt = depth_r;
    v_nxt = v_r; next_nxt = next_r; visited_nxt = visited_r; onpath_nxt = onpath_r;
    tvis_nxt = tvis_r; tv_nxt = tv_r; cur_nxt = cur_r; y_nxt = y_r; len_nxt = len_r;
    seen_nxt = seen_r; prev_nxt = prev_r; u_nxt = u_r; hit_nxt = hit_r;
    emit_rd_nxt = emit_rd_r; found_nxt = found_r; trunc_nxt = trunc_r; cnt_nxt = cnt_r;
    in_ready = 1'b0;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
    pth_we = 1'b0; pth_waddr = '0; pth_wdata = '0; pth_raddr = '0;
    push = 1'b0; push_data = '0;
    unique case (state_r)
      // Sweep all rows to zero after reset or a clear request.
      wgdd_pkg::ST_CLEAR: begin
        ram_we = 1'b1; ram_waddr = clr_r; ram_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == VW'(NV - 1)) begin
          state_nxt = wgdd_pkg::ST_IDLE;
        end
      end
      wgdd_pkg::ST_IDLE: begin
        in_ready = !out_full;
        if (in_valid && !out_full) begin
          req_nxt = in_req;
          clr_nxt = '0;
          priority if (in_req.kind == wgdd_pkg::KIND_CLEAR) begin
            state_nxt = wgdd_pkg::ST_CLEAR;
          end else if (in_req.kind == wgdd_pkg::KIND_REQUEST ||
                       in_req.kind == wgdd_pkg::KIND_ALLOC ||
                       in_req.kind == wgdd_pkg::KIND_DEALLOC) begin
            state_nxt = wgdd_pkg::ST_EDGE_RD;
          end else if (in_req.kind == wgdd_pkg::KIND_DETECT) begin
            cnt_nxt = '0; visited_nxt = '0; onpath_nxt = '0;
            found_nxt = 1'b0; trunc_nxt = 1'b0; root_nxt = '0;
            state_nxt = wgdd_pkg::ST_ROOT;
          end else begin
            state_nxt = wgdd_pkg::ST_IDLE;
          end
        end
      end
      // Edge edit: read the process row (request, request clear) or the lock row.
      wgdd_pkg::ST_EDGE_RD: begin
        ram_raddr = (req_r.kind == wgdd_pkg::KIND_REQUEST ||
                     req_r.kind == wgdd_pkg::KIND_UNREQ) ? pid_v : lid_v;
        state_nxt = wgdd_pkg::ST_EDGE_WR;
      end
      wgdd_pkg::ST_EDGE_WR: begin
        ram_we = 1'b1;
        priority if (req_r.kind == wgdd_pkg::KIND_REQUEST) begin
          ram_waddr = pid_v; ram_wdata = ram_rdata | (row_t_bit(lid_v));
          state_nxt = wgdd_pkg::ST_IDLE;
        end else if (req_r.kind == wgdd_pkg::KIND_ALLOC) begin
          ram_waddr = lid_v; ram_wdata = ram_rdata | (row_t_bit(pid_v));
          // Second pass clears the request edge on the process row.
          req_nxt.kind = wgdd_pkg::KIND_UNREQ;
          state_nxt = wgdd_pkg::ST_EDGE_RD;
        end else if (req_r.kind == wgdd_pkg::KIND_DEALLOC) begin
          ram_waddr = lid_v; ram_wdata = ram_rdata & ~(row_t_bit(pid_v));
          state_nxt = wgdd_pkg::ST_IDLE;
        end else begin
          ram_waddr = pid_v; ram_wdata = ram_rdata & ~(row_t_bit(lid_v));
          state_nxt = wgdd_pkg::ST_IDLE;
        end
      end
      // Pick the next unvisited root.
      wgdd_pkg::ST_ROOT: begin
        if (root_r == CW'(NV)) begin
          state_nxt = wgdd_pkg::ST_SUMMARY;
        end else if (visited_r[VW'(root_r)]) begin
          root_nxt = root_r + 1'b1;
        end else begin
          visited_nxt[VW'(root_r)] = 1'b1;
          onpath_nxt[VW'(root_r)]  = 1'b1;
          v_nxt = VW'(root_r); next_nxt = '0; depth_nxt = CW'(1);
          root_nxt = root_r + 1'b1;
          state_nxt = wgdd_pkg::ST_DFS_RD;
        end
      end
      // Read the row of the frame at the top of the stack.
      wgdd_pkg::ST_DFS_RD: begin
        ram_raddr = v_r;
        state_nxt = wgdd_pkg::ST_DFS;
      end
      wgdd_pkg::ST_DFS: begin
        if (!a_hit) begin
          onpath_nxt[v_r] = 1'b0;
          depth_nxt = depth_r - 1'b1;
          if (depth_r == CW'(1)) begin
            state_nxt = wgdd_pkg::ST_ROOT;
          end else begin
            stk_raddr = VW'(depth_r - CW'(2));
            state_nxt = wgdd_pkg::ST_TR_RD;
            hit_nxt = 1'b1;
          end
        end else if (!visited_r[VW'(a_sel)]) begin
          // Push: save the current frame, descend.
          stk_we = 1'b1; stk_waddr = VW'(depth_r - CW'(1));
          stk_wdata = {v_r, a_sel + 1'b1};
          visited_nxt[VW'(a_sel)] = 1'b1;
          onpath_nxt[VW'(a_sel)]  = 1'b1;
          v_nxt = VW'(a_sel); next_nxt = '0; depth_nxt = depth_r + 1'b1;
          state_nxt = wgdd_pkg::ST_DFS_RD;
        end else if (onpath_r[VW'(a_sel)]) begin
          // Back edge: trace one cycle through v.
          found_nxt = 1'b1;
          tv_nxt = v_r; cur_nxt = v_r; y_nxt = '0; len_nxt = CW'(1);
          tvis_nxt = '0; tvis_nxt[v_r] = 1'b1;
          pth_we = 1'b1; pth_waddr = '0; pth_wdata = v_r;
          hit_nxt = 1'b0;
          state_nxt = wgdd_pkg::ST_TR_RD;
        end else begin
          next_nxt = a_sel + 1'b1;
          state_nxt = wgdd_pkg::ST_DFS_RD;
        end
      end
      // Shared read state: stack pop (hit_r) or trace row read.
      wgdd_pkg::ST_TR_RD: begin
        if (hit_r) begin
          v_nxt = VW'(stk_rdata >> CW);
          next_nxt = CW'(stk_rdata);
          hit_nxt = 1'b0;
          state_nxt = wgdd_pkg::ST_DFS_RD;
        end else begin
          ram_raddr = cur_r;
          state_nxt = wgdd_pkg::ST_TR;
        end
      end
      // Trace step: look at the next candidate neighbour of cur.
      wgdd_pkg::ST_TR: begin
        if (!ys_hit) begin
          // Dead end cannot occur on a true back edge; drop the trace.
          onpath_nxt = '0;
          state_nxt = wgdd_pkg::ST_ROOT;
        end else if (VW'(ys_sel) == tv_r) begin
          len_nxt = len_r - 1'b1;
          pth_raddr = VW'(len_r - 1'b1);
          emit_rd_nxt = 1'b0;
          state_nxt = wgdd_pkg::ST_EMIT;
        end else if (!tvis_r[VW'(ys_sel)] && len_r < CW'(NV)) begin
          seen_nxt = '0; seen_nxt[VW'(ys_sel)] = 1'b1;
          prev_nxt = '1; u_nxt = '0; hit_nxt = 1'b0;
          y_nxt = ys_sel;
          state_nxt = wgdd_pkg::ST_REACH_RD;
        end else begin
          y_nxt = ys_sel + 1'b1;
          state_nxt = wgdd_pkg::ST_TR_RD;
        end
      end
      // Reachability closure: sweep rows of seen vertices until stable.
      wgdd_pkg::ST_REACH_RD: begin
        ram_raddr = VW'(u_r);
        state_nxt = wgdd_pkg::ST_REACH;
      end
      wgdd_pkg::ST_REACH: begin
        if (seen_r[VW'(u_r)]) begin
          seen_nxt = seen_r | (ram_rdata & ~tvis_r);
          if (ram_rdata[tv_r]) begin
            hit_nxt = 1'b1;
          end
        end
        if (hit_nxt) begin
          // Reaches v: extend the path and go back to a trace row read.
          pth_we = 1'b1; pth_waddr = VW'(len_r); pth_wdata = VW'(y_r);
          tvis_nxt[VW'(y_r)] = 1'b1;
          len_nxt = len_r + 1'b1;
          cur_nxt = VW'(y_r); y_nxt = '0;
          hit_nxt = 1'b0;
          state_nxt = wgdd_pkg::ST_TR_RD;
        end else if (u_r == CW'(NV - 1)) begin
          if (seen_nxt == prev_r) begin
            y_nxt = y_r + 1'b1;
            state_nxt = wgdd_pkg::ST_TR_RD;
          end else begin
            prev_nxt = seen_nxt; u_nxt = '0;
            state_nxt = wgdd_pkg::ST_REACH_RD;
          end
        end else begin
          u_nxt = u_r + 1'b1;
          state_nxt = wgdd_pkg::ST_REACH_RD;
        end
      end
      // Emit the path from its far end back to v.
      wgdd_pkg::ST_EMIT: begin
        pth_raddr = VW'(len_r);
        if (!emit_rd_r) begin
          emit_rd_nxt = 1'b1;
        end else if (!out_full) begin
          if (cnt_r < wgdd_pkg::RCW'(wgdd_pkg::MAX_RESULTS - 1)) begin
            push = 1'b1;
            push_data.node = 4'(pth_rdata);
            push_data.node_valid = 1'b1;
            push_data.cycle_end = (len_r == '0);
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            trunc_nxt = 1'b1;
          end
          if (len_r == '0) begin
            onpath_nxt = '0;
            state_nxt = wgdd_pkg::ST_ROOT;
          end else begin
            len_nxt = len_r - 1'b1;
            pth_raddr = VW'(len_r - 1'b1);
          end
        end else begin
          pth_raddr = VW'(len_r);
        end
      end
      wgdd_pkg::ST_SUMMARY: begin
        if (!out_full) begin
          push = 1'b1;
          push_data.deadlock_found = found_r;
          push_data.truncated = trunc_r;
          push_data.last = 1'b1;
          state_nxt = wgdd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wgdd_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/wait_graph_deadlock_detector.sv
// Edge requests read a row, then write it (allocate does two such passes); clear zeroes
// every row; a detect request reads a row, then decides, per depth-first search step,
// plus a reachability sweep over the rows, pass by pass, for each traced cycle step.
// One request is handled at a time; the edge RAM read port sets the pace.
// Reset: synchronous active-low rst_n; after reset a clearing pass zeroes the edge
// matrix and no request is accepted meanwhile.
`default_nettype none
module wait_graph_deadlock_detector (
  input  wire logic clk,
  input  wire logic rst_n,
  wgdd_chan_if.sink   in_chan,
  wgdd_chan_if.source out_chan
);
  logic full;
  logic push;
  wgdd_pkg::result_t push_data;

  // Search engine with its edge, stack and path memories.
  wgdd_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready), .in_req(in_chan.data),
    .push(push), .push_data(push_data), .out_full(full)
  );

  // Result output register.
  wgdd_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready), .out_data(out_chan.data)
  );
endmodule
`default_nettype wire
